### hdl/mpnc_pkg.sv
// Package for the maze pixel node classifier.
// Holds the item structs, the node class codes and the register map.
// No dependencies; every other file imports this package.
`default_nettype none

package mpnc_pkg;

  // Register map of the configuration port.
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 11;

  localparam logic [CfgIndexW-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_DARK_THRESHOLD = 2'd2;

  localparam logic [10:0] IMAGE_WIDTH_RESET    = 11'd1024;
  localparam logic [10:0] IMAGE_HEIGHT_RESET   = 11'd1024;
  localparam logic [7:0]  DARK_THRESHOLD_RESET = 8'd127;

  // Smallest frame dimension in use.
  localparam logic [10:0] MIN_DIM = 11'd3;

  typedef enum logic [1:0] {
    NODE_NONE     = 2'd0,
    NODE_PATH     = 2'd1,
    NODE_DEAD_END = 2'd2
  } node_class_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  column;
    node_class_e node_class;
    logic        is_open;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

### hdl/mpnc_classify.sv
// Pixel thresholding and cross neighbourhood classification.
// Purely combinational; uses the types of mpnc_pkg.
`default_nettype none

module mpnc_classify (
  input  mpnc_pkg::pixel_t      pixel_i,
  input  logic [7:0]            thresh_i,
  input  logic [5:0]            window_i,
  input  logic                  right_i,
  output logic                  open_o,
  output logic                  center_o,
  output mpnc_pkg::node_class_e node_class_o
);
  import mpnc_pkg::*;

  logic [9:0] sum;
  logic [9:0] limit;
  logic       up, down, left;
  logic [2:0] open_cnt;

  // mean/3 <= t is the same as sum <= 3*t + 2, so no divider is needed.
  assign sum   = 10'(pixel_i.blue) + 10'(pixel_i.green) + 10'(pixel_i.red);
  assign limit = 10'({pixel_i.blue[0] & 1'b0, thresh_i, 1'b0}) + 10'(thresh_i) + 10'd2;
  assign open_o = (sum <= limit);

  // Window bits 0..2 are the column left of the newest one (up, center, down),
  // bits 3..5 the column before that.
  assign up       = window_i[0];
  assign center_o = window_i[1];
  assign down     = window_i[2];
  assign left     = window_i[4];
  assign open_cnt = 3'(up) + 3'(down) + 3'(left) + 3'(right_i);

  always_comb begin
    node_class_o = NODE_NONE;
    if (center_o && (up || down) && (left || right_i)) begin
      node_class_o = NODE_PATH;
    end else if (center_o && (open_cnt == 3'd1)) begin
      node_class_o = NODE_DEAD_END;
    end
  end

endmodule

`default_nettype wire

### hdl/maze_pixel_node_classifier_top.sv
// Top level of the maze pixel node classifier: line stores, raster counters,
// window register, result register and configuration registers.
// Depends on mpnc_pkg and mpnc_classify.
//
//  Channel | Direction | Handshake                 | Payload
//  in      | input     | in_valid_i / in_stall_o   | in_data_i  (mpnc_pkg::pixel_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (mpnc_pkg::result_t)
//  cfg     | input     | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// One pixel item is accepted per clock unless stalled; each result is registered.
// The rate is set by the single read and write port of each line store RAM,
// which is read one pixel ahead so the data is ready when the item arrives.
// Reset clears the counters and the window and presets the configuration; the line
// stores are not cleared. The input stalls only while a held result is stalled.
`default_nettype none

module maze_pixel_node_classifier_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  mpnc_pkg::pixel_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output mpnc_pkg::result_t                  out_data_o,
  input  logic                               cfg_we_i,
  input  logic [mpnc_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [mpnc_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import mpnc_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // Configuration registers.
  logic [10:0] width_q, height_q;
  logic [7:0]  thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMAGE_WIDTH_RESET;
      height_q <= IMAGE_HEIGHT_RESET;
      thresh_q <= DARK_THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:    width_q  <= cfg_wdata_i;
        REG_IMAGE_HEIGHT:   height_q <= cfg_wdata_i;
        REG_DARK_THRESHOLD: thresh_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Last column and last line, with the dimensions saturated into range.
  logic [COL_W-1:0] last_col;
  logic [ROW_W-1:0] last_row;

  always_comb begin
    if (width_q < MIN_DIM) begin
      last_col = COL_W'(2);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(width_q - 11'd1);
    end
    if (height_q < MIN_DIM) begin
      last_row = ROW_W'(2);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      last_row = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      last_row = ROW_W'(height_q - 11'd1);
    end
  end

  // Handshake.
  logic in_acc;
  logic out_valid_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Raster position of the next pixel.
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_q >= last_col) begin
        col_d = '0;
        row_d = (row_q >= last_row) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // Line stores. The read address runs one pixel ahead, so the registered
  // read data always belongs to the column in col_q.
  logic             upper_mem [MAX_WIDTH];
  logic             middle_mem [MAX_WIDTH];
  logic             upper_rd_q, middle_rd_q;
  logic [COL_W-1:0] rd_addr;
  logic             pix_open;

  assign rd_addr = in_acc ? col_d : col_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      upper_mem[col_q]  <= middle_rd_q;
      middle_mem[col_q] <= pix_open;
    end
    upper_rd_q  <= upper_mem[rd_addr];
    middle_rd_q <= middle_mem[rd_addr];
  end

  // Cross neighbourhood classification.
  logic [5:0]  window_q, window_d;
  logic        center;
  node_class_e node_class;

  mpnc_classify u_classify (
    .pixel_i      (in_data_i),
    .thresh_i     (thresh_q),
    .window_i     (window_q),
    .right_i      (middle_rd_q),
    .open_o       (pix_open),
    .center_o     (center),
    .node_class_o (node_class)
  );

  assign window_d = {window_q[2:0], pix_open, middle_rd_q, upper_rd_q};

  logic emit;
  assign emit = (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      window_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (in_acc) begin
        window_q <= window_d;
      end
    end
  end

  // Result register.
  result_t out_data_q, out_data_d;
  logic    out_valid_d;

  always_comb begin
    out_data_d.row        = 10'(32'(row_q) - 32'd1);
    out_data_d.column     = 10'(32'(col_q) - 32'd1);
    out_data_d.node_class = node_class;
    out_data_d.is_open    = center;
    out_data_d.last       = (row_q == last_row) && (col_q == last_col);
    if (in_acc) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A pixel from the third row and column on always leaves a result in the next cycle.
  a_interior_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && emit |=> out_valid_o)
    else $error("interior pixel gave no result");

  // A pixel in the first two rows or columns never leaves a result behind.
  a_border_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !emit |=> !out_valid_o)
    else $error("border pixel gave a result");

  // The input only stalls behind a held result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // Only an open pixel can be a node.
  a_node_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.node_class != NODE_NONE) |-> out_data_o.is_open)
    else $error("node reported on a closed pixel");

  // The last flag marks the bottom right interior pixel.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |->
      out_data_o.column == 10'(32'(last_col) - 32'd1))
    else $error("last flag on the wrong column");

endmodule

`default_nettype wire
